>>> design/pst_pkg.sv
// shared types and constants for the pointer size hash table
package pst_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   localparam int SIZE_W      = 48;

   localparam logic [1:0] KIND_PUT    = 2'd0;
   localparam logic [1:0] KIND_GET    = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_IGNORED   = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SIZE_W-1:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_LO,
      ST_HASH_HI,
      ST_PROBE
   } state_type;

endpackage

>>> design/pointer_size_hash_table_unit.sv
// pointer size hash table: open addressing with linear probing, one slot read per cycle
//
// After reset the unit clears its slot memory, one slot per cycle, with busy high. A word
// is taken when start is high and busy is low. Invalid operations (put with zero key or
// size, put with the table full, get or delete of key zero, unknown kind) answer on
// rsp_valid in the next cycle and leave busy low. Any other operation forms the home slot
// from two partial products of the key and the depth in ST_HASH_LO and ST_HASH_HI, then
// walks the slots from home upward with one memory read per cycle and one compare per
// cycle on the registered read data, probing at most TABLE_DEPTH minus the home slot
// slots. The result is shown on rsp_valid for one cycle and cannot be held off by the
// receiver.
module pointer_size_hash_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pst_pkg::req_type req_data,
   output logic             rsp_valid,
   output pst_pkg::rsp_type rsp_data
);
   import pst_pkg::*;

   localparam int MUL_W = 32 + SLOT_W + 1;
   localparam logic [SLOT_W:0]   DEPTH_P   = (SLOT_W + 1)'(TABLE_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type         state_ff, state_in;
   req_type           op_ff, op_in;
   logic [MUL_W-1:0]  lo_prod_ff, lo_prod_in;
   logic [SLOT_W:0]   probe_addr_ff, probe_addr_in;
   logic [SLOT_W-1:0] cmp_addr_ff, cmp_addr_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [SLOT_W-1:0] clear_addr_ff, clear_addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   slot_type          mem [TABLE_DEPTH];
   slot_type          rd_data_ff;
   logic              mem_re;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   slot_type          mem_wdata;

   logic [MUL_W:0]    hi_sum;
   logic              hit;

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[probe_addr_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lo_prod_ff    <= lo_prod_in;
      probe_addr_ff <= probe_addr_in;
      cmp_addr_ff   <= cmp_addr_in;
      rsp_ff        <= rsp_in;
   end

   // upper part of key times depth, high half on top of the low partial product
   assign hi_sum = (MUL_W + 1)'(op_ff.key[63:32]) * (MUL_W + 1)'(TABLE_DEPTH)
                 + (MUL_W + 1)'(lo_prod_ff >> 32);

   // put looks for an empty slot, get and delete for the key
   assign hit = (op_ff.kind == KIND_PUT) ? (rd_data_ff.key == '0)
                                         : (rd_data_ff.key == op_ff.key);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lo_prod_in    = lo_prod_ff;
      probe_addr_in = probe_addr_ff;
      cmp_addr_in   = cmp_addr_ff;
      cmp_valid_in  = cmp_valid_ff;
      clear_addr_in = clear_addr_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cmp_addr_ff;
      mem_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in            = req_data;
               rsp_in.value_out = '0;
               case (req_data.kind)
                  KIND_PUT: begin
                     if (req_data.key == '0 || req_data.value_in == '0) begin
                        rsp_in.status = STATUS_IGNORED;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff >= DEPTH_CNT) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_HASH_LO;
                     end
                  end
                  KIND_GET, KIND_DELETE: begin
                     if (req_data.key == '0) begin
                        rsp_in.status = STATUS_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_HASH_LO;
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_IGNORED;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_HASH_LO: begin
            lo_prod_in = MUL_W'(op_ff.key[31:0]) * MUL_W'(TABLE_DEPTH);
            state_in   = ST_HASH_HI;
         end
         ST_HASH_HI: begin
            probe_addr_in = {1'b0, hi_sum[32 +: SLOT_W]};
            cmp_valid_in  = 1'b0;
            state_in      = ST_PROBE;
         end
         ST_PROBE: begin
            // issue the next read while comparing the previous one
            cmp_valid_in = 1'b0;
            if (probe_addr_ff < DEPTH_P) begin
               mem_re        = 1'b1;
               cmp_valid_in  = 1'b1;
               cmp_addr_in   = probe_addr_ff[SLOT_W-1:0];
               probe_addr_in = probe_addr_ff + 1'b1;
            end
            if (cmp_valid_ff) begin
               rsp_in.value_out = '0;
               if (hit) begin
                  rsp_in.status = STATUS_DONE;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
                  mem_we        = 1'b1;
                  mem_waddr     = cmp_addr_ff;
                  case (op_ff.kind)
                     KIND_PUT: begin
                        mem_wdata.key  = op_ff.key;
                        mem_wdata.size = op_ff.value_in;
                        count_in       = count_ff + 1'b1;
                     end
                     KIND_GET: begin
                        mem_we           = 1'b0;
                        rsp_in.value_out = rd_data_ff.size;
                     end
                     default: begin
                        mem_wdata = '0;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                  endcase
               end else if (cmp_addr_ff == LAST_SLOT) begin
                  rsp_in.status = (op_ff.kind == KIND_PUT) ? STATUS_FULL : STATUS_NOT_FOUND;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above table depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted word neither answered nor in progress");

   a_value_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |-> rsp_data.value_out == '0)
      else $error("nonzero value on a result that is not done");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> probe_addr_ff <= DEPTH_P)
      else $error("probe pointer past table end");
`endif

endmodule

>>> tb/tb.sv
// self-checking bench for the pointer size hash table unit with a shadow copy of the table
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pst_pkg::*;

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      req_type word;
      rsp_type rsp;
   } due_type;

   // shadow of the slot store plus the answers still owed by the unit
   class size_table_model;
      logic [KEY_W-1:0]  slot_key  [TABLE_DEPTH];
      logic [SIZE_W-1:0] slot_size [TABLE_DEPTH];
      int                entries;
      due_type           due [$];
      int                errors;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]  = '0;
            slot_size[i] = '0;
         end
         entries = 0;
         errors  = 0;
      endfunction

      // upper half of key times depth
      function int home_of(logic [KEY_W-1:0] key);
         logic [127:0] prod;
         logic [127:0] depth_w;
         depth_w = TABLE_DEPTH;
         prod    = {64'd0, key} * depth_w;
         return int'(prod[127:64]);
      endfunction

      function int find_slot(logic [KEY_W-1:0] key);
         if (key == '0) return -1;
         for (int i = home_of(key); i < TABLE_DEPTH; i++) begin
            if (slot_key[i] == key) return i;
         end
         return -1;
      endfunction

      // apply one accepted word to the shadow table and queue its answer
      function void apply_op(req_type w);
         due_type d;
         int      at;
         d.word          = w;
         d.rsp.status    = STATUS_IGNORED;
         d.rsp.value_out = '0;
         case (w.kind)
            KIND_PUT: begin
               if (w.key == '0 || w.value_in == '0) begin
                  d.rsp.status = STATUS_IGNORED;
               end else if (entries >= TABLE_DEPTH) begin
                  d.rsp.status = STATUS_FULL;
               end else begin
                  d.rsp.status = STATUS_FULL;
                  at = home_of(w.key);
                  while (at < TABLE_DEPTH && slot_key[at] != '0) at++;
                  if (at < TABLE_DEPTH) begin
                     slot_key[at]  = w.key;
                     slot_size[at] = w.value_in;
                     entries++;
                     d.rsp.status = STATUS_DONE;
                  end
               end
            end
            KIND_GET: begin
               at = find_slot(w.key);
               if (at >= 0) begin
                  d.rsp.status    = STATUS_DONE;
                  d.rsp.value_out = slot_size[at];
               end else begin
                  d.rsp.status = STATUS_NOT_FOUND;
               end
            end
            KIND_DELETE: begin
               at = find_slot(w.key);
               if (at >= 0) begin
                  slot_key[at]  = '0;
                  slot_size[at] = '0;
                  if (entries > 0) entries--;
                  d.rsp.status = STATUS_DONE;
               end else begin
                  d.rsp.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               d.rsp.status = STATUS_IGNORED;
            end
         endcase
         due.push_back(d);
      endfunction

      function void check_rsp(rsp_type got);
         due_type d;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d size %h", got.status, got.value_out);
            return;
         end
         d = due.pop_front();
         if (got.status !== d.rsp.status || got.value_out !== d.rsp.value_out) begin
            errors++;
            if (errors <= 10)
               $display("mismatch kind %0d key %h: expected status %0d size %h, got status %0d size %h",
                        d.word.kind, d.word.key, d.rsp.status, d.rsp.value_out,
                        got.status, got.value_out);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   size_table_model  table_shadow;
   logic [KEY_W-1:0] recent_keys [$];
   int               calm_left;
   bit               gaps_on;
   int               cycle_count = 0;

   pointer_size_hash_table_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) table_shadow.check_rsp(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[SIZE_W-1:0];
   endfunction

   // random key whose home slot is h
   function automatic logic [KEY_W-1:0] key_at_home(int h);
      logic [127:0] hw;
      logic [127:0] depth_w;
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] k;
      hw      = h;
      depth_w = TABLE_DEPTH;
      lo      = ((hw << 64) + depth_w - 1) / depth_w;
      hi      = (((hw + 1) << 64) + depth_w - 1) / depth_w;
      k       = lo + ({64'd0, random_key()} % (hi - lo));
      if (k[KEY_W-1:0] == '0) k = 1;
      return k[KEY_W-1:0];
   endfunction

   // mostly keys seen lately, then a crowded band at the table end, then anything
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      if (r < 85) return key_at_home($urandom_range(TABLE_DEPTH - 64, TABLE_DEPTH - 1));
      return random_key();
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      logic [SIZE_W-1:0] s;
      case ($urandom_range(0, 19))
         0:       s = '1;
         1:       s = 1;
         default: s = random_size();
      endcase
      if (s == '0) s = 1;
      return s;
   endfunction

   task automatic send_word(req_type w);
      if (gaps_on) begin
         if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 49) == 0) begin
            calm_left = $urandom_range(20, 60);
         end else if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      table_shadow.apply_op(w);
      if (w.key != '0) begin
         recent_keys.push_back(w.key);
         if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      end
   endtask

   task automatic send_op(logic [1:0] kind, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
      req_type w;
      w.kind     = kind;
      w.key      = key;
      w.value_in = size;
      send_word(w);
   endtask

   task automatic random_ops(int n, int put_pct, int get_pct, int del_pct);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < put_pct) begin
            send_op(KIND_PUT, pick_key(), pick_size());
         end else if (r < put_pct + get_pct) begin
            send_op(KIND_GET, pick_key(), random_size());
         end else if (r < put_pct + get_pct + del_pct) begin
            send_op(KIND_DELETE, pick_key(), random_size());
         end else begin
            // malformed words
            case ($urandom_range(0, 3))
               0:       send_op(KIND_PUT, '0, pick_size());
               1:       send_op(KIND_PUT, pick_key(), '0);
               2:       send_op(KIND_UNUSED, random_key(), random_size());
               default: send_op($urandom_range(0, 1) ? KIND_GET : KIND_DELETE, '0, random_size());
            endcase
         end
      end
   endtask

   initial begin
      logic [KEY_W-1:0] chain [4];
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      calm_left    = 0;
      gaps_on      = 1'b1;
      table_shadow = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // invalid words
      send_op(KIND_PUT, '0, pick_size());
      send_op(KIND_PUT, random_key() | 64'd1, '0);
      send_op(KIND_GET, '0, random_size());
      send_op(KIND_DELETE, '0, random_size());
      send_op(KIND_UNUSED, random_key(), random_size());
      // last slot taken, then no room before the end
      send_op(KIND_PUT, '1, '1);
      send_op(KIND_PUT, key_at_home(TABLE_DEPTH - 1), 1);
      send_op(KIND_GET, '1, random_size());
      // duplicate key: lowest slot answers first
      send_op(KIND_PUT, 64'd1, 1);
      send_op(KIND_GET, 64'd1, '0);
      send_op(KIND_PUT, 64'd1, 2);
      send_op(KIND_GET, 64'd1, '1);
      send_op(KIND_DELETE, 64'd1, '0);
      send_op(KIND_GET, 64'd1, '0);
      send_op(KIND_DELETE, 64'd1, '0);
      send_op(KIND_DELETE, 64'd1, '0);
      // miss from slot zero scans the whole table
      send_op(KIND_GET, key_at_home(0) | 64'd2, '0);
      send_op(KIND_DELETE, '1, '0);
      send_op(KIND_DELETE, '1, '0);
      // probe chain near the end, with a hole punched in it
      foreach (chain[i]) chain[i] = key_at_home(TABLE_DEPTH - 3);
      foreach (chain[i]) send_op(KIND_PUT, chain[i], pick_size());
      send_op(KIND_GET, chain[2], '0);
      send_op(KIND_DELETE, chain[1], '0);
      send_op(KIND_GET, chain[2], '0);

      random_ops(600, 40, 30, 22);

      // fill every free slot so the entry count reaches the depth
      for (int h = TABLE_DEPTH - 1; h >= 0; h--) begin
         if (table_shadow.slot_key[h] == '0) send_op(KIND_PUT, key_at_home(h), pick_size());
      end
      send_op(KIND_PUT, random_key() | 64'd1, pick_size());
      send_op(KIND_PUT, key_at_home(0), pick_size());

      random_ops(120, 30, 30, 35);
      gaps_on = 1'b0;
      random_ops(130, 30, 30, 35);
      start <= 1'b0;

      while (table_shadow.due.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (table_shadow.errors == 0 && table_shadow.due.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
